### sv/srlw_pkg.sv
// ----------------------------------------------------------------------------
// srlw_pkg
// Shared types, widths, codes and the fractional exp table of the
// self-repelling lattice walker.
// ----------------------------------------------------------------------------
package srlw_pkg;

  // Lattice side is a power of two, so wrapping is plain modular arithmetic.
  localparam int LOG_SIDE     = 10;
  localparam int LATTICE_SIDE = 1 << LOG_SIDE;
  localparam int COUNT_BITS   = 16;
  localparam int FRAC_BITS    = 16;   // equals the width of the step fractions
  localparam int POS_W        = LOG_SIDE + FRAC_BITS;
  localparam int CELL_W       = LOG_SIDE;
  localparam int ADDR_W       = 2 * LOG_SIDE;
  localparam int EPOCH_BITS   = 8;
  localparam int STEP_W       = 24;
  localparam int BETA_W       = 16;
  localparam int RAD_W        = 16;
  localparam int RW           = RAD_W + FRAC_BITS - 8;
  localparam int DRAW_W       = 16;
  localparam int WGT_W        = 17;
  localparam int TOT_W        = 21;
  localparam int EXP_W        = 31;
  localparam int MUL_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 26;
  localparam int X_LIMIT      = 12 * 256;
  localparam logic [28:0] EXP_M1_Q30 = 29'd395007542;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA   = 3'd0,
    CFG_TGT_X  = 3'd1,
    CFG_TGT_Y  = 3'd2,
    CFG_RADIUS = 3'd3,
    CFG_START_X = 3'd4,
    CFG_START_Y = 3'd5,
    CFG_LIMIT  = 3'd6
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_CK0, S_CK1, S_CK2, S_CK3,
    S_RD, S_RW, S_X, S_EN, S_EM,
    S_PK, S_PW, S_SR, S_MV,
    S_NR, S_NW, S_OUT
  } state_t;

  typedef logic [EXP_W-1:0] exp_tab_t [256];

  // exp(-f/256) in Q30, nine-term Taylor series, each term truncated.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    longint unsigned t, term, ev, od, e;
    for (int f = 0; f < 256; f++) begin
      t = longint'(f) << 22;
      term = 64'd1 << 30;
      ev = term;
      od = 0;
      term = ((term * t) >> 30) / 1; od = od + term;
      term = ((term * t) >> 30) / 2; ev = ev + term;
      term = ((term * t) >> 30) / 3; od = od + term;
      term = ((term * t) >> 30) / 4; ev = ev + term;
      term = ((term * t) >> 30) / 5; od = od + term;
      term = ((term * t) >> 30) / 6; ev = ev + term;
      term = ((term * t) >> 30) / 7; od = od + term;
      term = ((term * t) >> 30) / 8; ev = ev + term;
      e = (ev > od) ? ev - od : 64'd0;
      tab[f] = e[EXP_W-1:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_FRAC_TAB = build_exp_tab();

endpackage

### sv/srlw_ram.sv
// ----------------------------------------------------------------------------
// srlw_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module srlw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/srlw_mul.sv
// ----------------------------------------------------------------------------
// srlw_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module srlw_mul (
  input  logic                           clk,
  input  logic [srlw_pkg::MUL_W-1:0]     a,
  input  logic [srlw_pkg::MUL_W-1:0]     b,
  output logic [2*srlw_pkg::MUL_W-1:0]   p_r
);
  import srlw_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

### sv/self_repelling_lattice_walker_core.sv
// ----------------------------------------------------------------------------
// self_repelling_lattice_walker_core
// Self-repelling walker on a toroidal lattice with per-cell visit counts.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on the out_ ports for exactly one cycle with out_valid high, and
// the receiver cannot hold it off. One item is in flight at a time. A step
// keeps busy high through a target check; unless that ends the run, each
// neighbor cell follows with a count read, and when beta*count is below 12.0
// with one exp multiply per whole unit of beta*count (at most 11); then come
// the pick, the move, the count write-back when the cell changes, a final
// check and the result. The single-port count memory and the shared
// multiplier serialize these steps. A start item keeps busy high only for
// the target check and the result. Visit counts are tagged with a run epoch
// so a start need not touch the memory; after reset, and on every 255th
// start when the epoch wraps, a clearing pass over all LATTICE_SIDE*LATTICE_SIDE
// (2^20) count words runs with busy high.
// Configuration transfers are taken in any cycle (cfg_ready is always high)
// but are meant to be written only while the block is idle.
// ----------------------------------------------------------------------------
module self_repelling_lattice_walker_core #(
  parameter int COUNT_BITS = srlw_pkg::COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_action,
  input  logic [srlw_pkg::DRAW_W-1:0]       in_choice_draw,
  input  logic [15:0]                       in_step_frac_x,
  input  logic [15:0]                       in_step_frac_y,
  output logic                              out_valid,
  output logic [srlw_pkg::POS_W-1:0]        out_pos_x,
  output logic [srlw_pkg::POS_W-1:0]        out_pos_y,
  output logic [srlw_pkg::CELL_W-1:0]       out_cell_x,
  output logic [srlw_pkg::CELL_W-1:0]       out_cell_y,
  output logic                              out_changed_cell,
  output logic                              out_reached_target,
  output logic                              out_limit_hit,
  output logic [srlw_pkg::STEP_W-1:0]       out_steps_taken,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srlw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srlw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import srlw_pkg::*;

  localparam int MEM_W = EPOCH_BITS + COUNT_BITS;
  localparam int X_W   = BETA_W + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration registers
  logic [BETA_W-1:0]  beta_r;
  logic [CELL_W-1:0]  tgt_x_r, tgt_y_r;
  logic [RAD_W-1:0]   radius_r;
  logic [POS_W-1:0]   start_x_r, start_y_r;
  logic [STEP_W-1:0]  limit_r;

  // walker state and control
  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   walker_x_r, walker_y_r;
  logic [STEP_W-1:0]  step_cnt_r;
  logic               run_done_r;
  logic [EPOCH_BITS-1:0] epoch_r;
  logic [ADDR_W-1:0]  clr_r;
  logic               start_pend_r;
  logic               post_r;

  // per-step working registers
  logic [DRAW_W-1:0]  draw_r;
  logic [15:0]        frac_x_r, frac_y_r;
  logic [CELL_W-1:0]  cx_r, cy_r;
  logic [1:0]         i_r, j_r;
  logic [3:0]         k_r;
  logic [WGT_W-1:0]   w_r [9];
  logic [TOT_W-1:0]   total_r, acc_r, pick_r;
  logic [EXP_W-1:0]   e_r;
  logic [3:0]         n_r;
  logic [2*POS_W:0]   sq_r;
  logic               changed_r, reached_r, limit_hit_r;

  // memory and multiplier
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [MEM_W-1:0]   mem_wdata, mem_rdata;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_r;

  srlw_ram #(.WIDTH(MEM_W), .DEPTH(1 << ADDR_W)) u_counts (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  srlw_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_r)
  );

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic               accept;
  logic [POS_W-1:0]   tx, ty, dx, dy;
  logic [RW-1:0]      rad;
  logic               near_tgt, lim_now;
  logic [CELL_W-1:0]  gx, gy;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [X_W-1:0]     x_val;
  logic               x_big;
  logic [EXP_W:0]     e_rnd;
  logic [WGT_W-1:0]   w_exp, w_new;
  logic [2*MUL_W-1:0] e_mul_rnd;
  logic [TOT_W-1:0]   acc_try;
  logic               hit;
  logic [POS_W-1:0]   nx_pos, ny_pos;
  logic               moved;
  logic [EPOCH_BITS-1:0] epoch_inc;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign tx  = {tgt_x_r, {FRAC_BITS{1'b0}}};
  assign ty  = {tgt_y_r, {FRAC_BITS{1'b0}}};
  assign dx  = (walker_x_r > tx) ? walker_x_r - tx : tx - walker_x_r;
  assign dy  = (walker_y_r > ty) ? walker_y_r - ty : ty - walker_y_r;
  // radius never reaches 2^30 at these widths, so the exact compare decides
  assign rad = {radius_r, {(FRAC_BITS-8){1'b0}}};
  assign near_tgt = ((2*MUL_W)'(sq_r) <= mul_r);
  assign lim_now  = (step_cnt_r >= limit_r);

  // wrapped neighbor cell, offset i-1 / j-1
  assign gx = cx_r + CELL_W'(i_r) - CELL_W'(1);
  assign gy = cy_r + CELL_W'(j_r) - CELL_W'(1);

  // stale epoch reads as an unvisited cell
  assign cnt_rd = (mem_rdata[MEM_W-1:COUNT_BITS] == epoch_r) ?
                  mem_rdata[COUNT_BITS-1:0] : '0;

  assign x_val = mul_r[X_W-1:0];
  assign x_big = (x_val >= X_W'(X_LIMIT));

  assign e_rnd     = {1'b0, e_r} + (EXP_W+1)'(1 << 13);
  assign w_exp     = e_rnd[EXP_W-1:14];
  assign w_new     = (state_r == S_X) ? WGT_W'(1) :
                     ((w_exp == '0) ? WGT_W'(1) : w_exp);
  assign e_mul_rnd = mul_r + (2*MUL_W)'(1 << 29);

  assign acc_try = acc_r + TOT_W'(w_r[k_r]);
  assign hit     = (pick_r < acc_try) || (k_r == 4'd8);

  // move along the chosen axes; the position width wraps the torus
  always_comb begin
    case (i_r)
      2'd0:    nx_pos = walker_x_r - POS_W'(frac_x_r);
      2'd2:    nx_pos = walker_x_r + POS_W'(frac_x_r);
      default: nx_pos = walker_x_r;
    endcase
    case (j_r)
      2'd0:    ny_pos = walker_y_r - POS_W'(frac_y_r);
      2'd2:    ny_pos = walker_y_r + POS_W'(frac_y_r);
      default: ny_pos = walker_y_r;
    endcase
  end

  assign moved = (nx_pos[POS_W-1:FRAC_BITS] != cx_r) ||
                 (ny_pos[POS_W-1:FRAC_BITS] != cy_r);
  assign epoch_inc = epoch_r + EPOCH_BITS'(1);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = start_pend_r ? S_CK0 : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (!in_action && (epoch_inc == '0)) begin
            state_nxt = S_CLEAR;
          end else begin
            state_nxt = S_CK0;
          end
        end
      end
      S_CK0: state_nxt = S_CK1;
      S_CK1: state_nxt = S_CK2;
      S_CK2: state_nxt = S_CK3;
      S_CK3: begin
        if (!post_r && !near_tgt && !lim_now) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_RD: state_nxt = S_RW;
      S_RW: state_nxt = S_X;
      S_X: begin
        if (x_big) begin
          state_nxt = (k_r == 4'd8) ? S_PK : S_RD;
        end else begin
          state_nxt = S_EN;
        end
      end
      S_EN: begin
        if (n_r == '0) begin
          state_nxt = (k_r == 4'd8) ? S_PK : S_RD;
        end else begin
          state_nxt = S_EM;
        end
      end
      S_EM: state_nxt = S_EN;
      S_PK: state_nxt = S_PW;
      S_PW: state_nxt = S_SR;
      S_SR: begin
        if (hit) begin
          state_nxt = S_MV;
        end
      end
      S_MV:  state_nxt = moved ? S_NR : S_CK0;
      S_NR:  state_nxt = S_NW;
      S_NW:  state_nxt = S_CK0;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer: memory port, multiplier operands, handshake
  // --------------------------------------------------------------------------
  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_OUT);
    mem_we    = 1'b0;
    mem_addr  = {walker_x_r[POS_W-1:FRAC_BITS], walker_y_r[POS_W-1:FRAC_BITS]};
    mem_wdata = {epoch_r, (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_BITS'(1)};
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '0;
      end
      S_RD: mem_addr = {gx, gy};
      S_NW: mem_we = 1'b1;
      S_CK0: begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
      end
      S_CK1: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
      end
      S_CK2: begin
        mul_a = MUL_W'(rad);
        mul_b = MUL_W'(rad);
      end
      S_RW: begin
        mul_a = MUL_W'(beta_r);
        mul_b = MUL_W'(cnt_rd);
      end
      S_EN: begin
        mul_a = MUL_W'(e_r);
        mul_b = MUL_W'(EXP_M1_Q30);
      end
      S_PK: begin
        mul_a = MUL_W'(draw_r);
        mul_b = MUL_W'(total_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign out_pos_x          = walker_x_r;
  assign out_pos_y          = walker_y_r;
  assign out_cell_x         = walker_x_r[POS_W-1:FRAC_BITS];
  assign out_cell_y         = walker_y_r[POS_W-1:FRAC_BITS];
  assign out_changed_cell   = changed_r;
  assign out_reached_target = reached_r;
  assign out_limit_hit      = limit_hit_r;
  assign out_steps_taken    = step_cnt_r;

  // --------------------------------------------------------------------------
  // Control and walker registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      beta_r       <= BETA_W'(256);
      tgt_x_r      <= CELL_W'(525);
      tgt_y_r      <= CELL_W'(512);
      radius_r     <= RAD_W'(256);
      start_x_r    <= POS_W'(33521664);
      start_y_r    <= POS_W'(33587200);
      limit_r      <= STEP_W'(1000000);
      walker_x_r   <= POS_W'(33521664);
      walker_y_r   <= POS_W'(33587200);
      step_cnt_r   <= '0;
      run_done_r   <= 1'b0;
      epoch_r      <= EPOCH_BITS'(1);
      clr_r        <= '0;
      start_pend_r <= 1'b0;
      post_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BETA:    beta_r    <= cfg_data[BETA_W-1:0];
          CFG_TGT_X:   tgt_x_r   <= cfg_data[CELL_W-1:0];
          CFG_TGT_Y:   tgt_y_r   <= cfg_data[CELL_W-1:0];
          CFG_RADIUS:  radius_r  <= cfg_data[RAD_W-1:0];
          CFG_START_X: start_x_r <= cfg_data[POS_W-1:0];
          CFG_START_Y: start_y_r <= cfg_data[POS_W-1:0];
          CFG_LIMIT:   limit_r   <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        S_CLEAR: clr_r <= clr_r + ADDR_W'(1);
        S_IDLE: begin
          if (accept) begin
            if (!in_action) begin
              // new run: advance the epoch, wrap forces a clearing pass
              walker_x_r   <= start_x_r;
              walker_y_r   <= start_y_r;
              step_cnt_r   <= '0;
              run_done_r   <= 1'b0;
              post_r       <= 1'b1;
              start_pend_r <= 1'b1;
              epoch_r      <= (epoch_inc == '0) ? EPOCH_BITS'(1) : epoch_inc;
            end else begin
              post_r <= run_done_r;
            end
          end
        end
        S_CK3: begin
          if (post_r || near_tgt || lim_now) begin
            if (near_tgt || lim_now) begin
              run_done_r <= 1'b1;
            end
          end
        end
        S_MV: begin
          walker_x_r <= nx_pos;
          walker_y_r <= ny_pos;
          step_cnt_r <= step_cnt_r + STEP_W'(1);
          post_r     <= 1'b1;
        end
        S_NW: post_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Step datapath (payload, no reset)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          draw_r    <= in_choice_draw;
          frac_x_r  <= in_step_frac_x;
          frac_y_r  <= in_step_frac_y;
          changed_r <= 1'b0;
        end
      end
      S_CK1: sq_r <= (2*POS_W+1)'(mul_r[2*POS_W-1:0]);
      S_CK2: sq_r <= sq_r + (2*POS_W+1)'(mul_r[2*POS_W-1:0]);
      S_CK3: begin
        reached_r   <= near_tgt;
        limit_hit_r <= lim_now;
        cx_r        <= walker_x_r[POS_W-1:FRAC_BITS];
        cy_r        <= walker_y_r[POS_W-1:FRAC_BITS];
        i_r         <= '0;
        j_r         <= '0;
        k_r         <= '0;
        total_r     <= '0;
      end
      S_X: begin
        e_r <= EXP_FRAC_TAB[x_val[7:0]];
        n_r <= x_val[11:8];
      end
      S_EM: begin
        e_r <= e_mul_rnd[30+EXP_W-1:30];
        n_r <= n_r - 4'd1;
      end
      S_PK: begin
        i_r   <= '0;
        j_r   <= '0;
        k_r   <= '0;
        acc_r <= '0;
      end
      S_PW: pick_r <= mul_r[16+TOT_W-1:16];
      S_MV: changed_r <= moved;
      default: ;
    endcase

    // store a finished weight and advance the neighbor counters
    if ((state_r == S_X && x_big) || (state_r == S_EN && n_r == '0)) begin
      w_r[k_r] <= w_new;
      total_r  <= total_r + TOT_W'(w_new);
    end
    if ((state_r == S_X && x_big) || (state_r == S_EN && n_r == '0) ||
        (state_r == S_SR && !hit)) begin
      k_r <= k_r + 4'd1;
      if (j_r == 2'd2) begin
        j_r <= '0;
        i_r <= i_r + 2'd1;
      end else begin
        j_r <= j_r + 2'd1;
      end
    end
    if (state_r == S_SR && !hit) begin
      acc_r <= acc_try;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_out_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_take_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_NW))
    else $error("count memory written outside clear or write-back");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (run_done_r && !(start && !busy && !in_action)) |=> run_done_r)
    else $error("finished run reopened without a start");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SR) |-> (k_r <= 4'd8))
    else $error("direction search ran past the neighborhood");

endmodule
